/* rtl/cdu_pkg.sv */
// ============================================================================
// cdu_pkg: shared types, constants and tables of the calendar date unit
// Reciprocal constants for the decimal split, month tables, decoded-date
// struct and a small mod-7 fold used for the weekday.
// ============================================================================
`default_nettype none

package cdu_pkg;

    localparam int unsigned DATE_W = 27;
    localparam int unsigned YEAR_W = 14;
    localparam int unsigned REM_W  = 14;
    localparam int unsigned MD_W   = 7;
    localparam int unsigned DOY_W  = 9;
    localparam int unsigned DNUM_W = 18;

    localparam int unsigned FIRST_YEAR = 1703;
    localparam int unsigned LAST_YEAR  = 2100;

    // floor(x / 10000) = (x * DIV10K_MUL) >> DIV10K_SHIFT, exact for x < 2**27
    localparam logic [DATE_W-1:0] DIV10K_MUL   = 27'd109951163;
    localparam int unsigned       DIV10K_SHIFT = 40;
    // floor(x / 100) = (x * DIV100_MUL) >> DIV100_SHIFT, exact for x < 2**14
    localparam logic [13:0]       DIV100_MUL   = 14'd10486;
    localparam int unsigned       DIV100_SHIFT = 20;

    // floor((FIRST_YEAR - 1) / 4): leap count offset of the epoch year
    localparam logic [YEAR_W-1:0] LEAP_BASE = 14'((FIRST_YEAR - 1) / 4);

    localparam logic [DOY_W-1:0] DAYS_COMMON = 9'd365;
    localparam logic [DOY_W-1:0] DAYS_LEAP   = 9'd366;

    // Decode stages after the input register, ending in the decoded-date register
    localparam int unsigned DEC_STAGES = 4;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [MD_W-1:0]   month;
        logic [MD_W-1:0]   day;
        logic              leap;
        logic              valid;
        logic [DOY_W-1:0]  doy;
        logic [DNUM_W-1:0] dnum;
    } t_dec;

    function automatic logic [DOY_W-1:0] month_start(input logic [MD_W-1:0] m);
        logic [DOY_W-1:0] s;
        case (m)
            7'd1:    s = 9'd0;
            7'd2:    s = 9'd31;
            7'd3:    s = 9'd59;
            7'd4:    s = 9'd90;
            7'd5:    s = 9'd120;
            7'd6:    s = 9'd151;
            7'd7:    s = 9'd181;
            7'd8:    s = 9'd212;
            7'd9:    s = 9'd243;
            7'd10:   s = 9'd273;
            7'd11:   s = 9'd304;
            7'd12:   s = 9'd334;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

    function automatic logic [4:0] month_len(input logic [MD_W-1:0] m,
                                             input logic leap);
        logic [4:0] n;
        case (m)
            7'd2:                             n = leap ? 5'd29 : 5'd28;
            7'd4, 7'd6, 7'd9, 7'd11:          n = 5'd30;
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8,
            7'd10, 7'd12:                     n = 5'd31;
            default:                          n = 5'd0;
        endcase
        return n;
    endfunction

    // 8 = 1 mod 7: sum the octal digits, fold once more, correct once
    function automatic logic [2:0] mod7(input logic [DNUM_W-1:0] v);
        logic [5:0] s1;
        logic [3:0] s2;
        s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9])
           + 6'(v[14:12]) + 6'(v[17:15]);
        s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
        return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : 3'(s2);
    endfunction

endpackage

`default_nettype wire

/* rtl/cdu_decode.sv */
// ============================================================================
// cdu_decode: pipelined decode of one packed YYYYMMDD date
// Splits the date by reciprocal multiplication, checks it against the
// calendar and forms day of year and day number since the epoch.
// ============================================================================
`default_nettype none

module cdu_decode (
    input  wire                           i_clk,
    input  wire [cdu_pkg::DATE_W-1:0]     i_date,
    output cdu_pkg::t_dec                 o_dec
);
    import cdu_pkg::*;

    // stage 1: year quotient
    logic [2*DATE_W-1:0] prod_y;
    logic [YEAR_W-1:0]   r1_y;
    logic [DATE_W-1:0]   r1_a;

    // stage 2: remainder below the year, century quotient
    logic [DATE_W-1:0]   rem_full;
    logic [27:0]         prod_c;
    logic [YEAR_W-1:0]   r2_y;
    logic [REM_W-1:0]    r2_rem;
    logic [7:0]          r2_yc;

    // stage 3: month quotient, leap flag, year base day number
    logic [27:0]         prod_m;
    logic [YEAR_W-1:0]   cent;
    logic                is_cent;
    logic [8:0]          yoff;
    logic [YEAR_W-1:0]   leap_cnt_full;
    logic [6:0]          leap_cnt;
    logic [YEAR_W-1:0]   r3_y;
    logic [REM_W-1:0]    r3_rem;
    logic [MD_W-1:0]     r3_m;
    logic                r3_leap;
    logic                r3_yr_ok;
    logic [DNUM_W-1:0]   r3_base;

    // stage 4: day, validity, ordinal day
    logic [REM_W-1:0]    day_full;
    logic [MD_W-1:0]     day;
    logic [4:0]          mlen;
    logic                ok;
    logic [DOY_W-1:0]    doy;
    t_dec                n_dec;
    t_dec                r_dec;

    assign prod_y = (2*DATE_W)'(i_date) * (2*DATE_W)'(DIV10K_MUL);

    always_ff @(posedge i_clk) begin
        r1_y <= prod_y[DIV10K_SHIFT +: YEAR_W];
        r1_a <= i_date;
    end

    assign rem_full = r1_a - DATE_W'(r1_y) * DATE_W'(10000);
    assign prod_c   = 28'(r1_y) * 28'(DIV100_MUL);

    always_ff @(posedge i_clk) begin
        r2_y   <= r1_y;
        r2_rem <= rem_full[REM_W-1:0];
        r2_yc  <= prod_c[DIV100_SHIFT +: 8];
    end

    assign prod_m  = 28'(r2_rem) * 28'(DIV100_MUL);
    assign cent    = 14'(r2_yc) * 14'(100);
    assign is_cent = (cent == r2_y);
    assign yoff    = 9'(r2_y - YEAR_W'(FIRST_YEAR));
    // leap years from the epoch up to the year before: 1800 and 1900 drop out
    assign leap_cnt_full = ((r2_y - 14'd1) >> 2) - LEAP_BASE
                         - 14'(r2_y > 14'd1800) - 14'(r2_y > 14'd1900);
    assign leap_cnt = leap_cnt_full[6:0];

    always_ff @(posedge i_clk) begin
        r3_y     <= r2_y;
        r3_rem   <= r2_rem;
        r3_m     <= prod_m[DIV100_SHIFT +: MD_W];
        r3_leap  <= ((r2_y[1:0] == 2'd0) && !is_cent) || (is_cent && (r2_yc[1:0] == 2'd0));
        r3_yr_ok <= (r2_y >= YEAR_W'(FIRST_YEAR)) && (r2_y <= YEAR_W'(LAST_YEAR));
        r3_base  <= DNUM_W'(yoff) * DNUM_W'(365) + DNUM_W'(leap_cnt);
    end

    always_comb begin
        day_full = r3_rem - 14'(r3_m) * 14'(100);
        day      = day_full[MD_W-1:0];
        mlen     = month_len(r3_m, r3_leap);
        ok       = r3_yr_ok && (mlen != 5'd0) && (day != 7'd0) && (day <= 7'(mlen));
        doy      = 9'(day) + month_start(r3_m)
                 + 9'((r3_m > 7'd2) && r3_leap);

        n_dec.year  = r3_y;
        n_dec.month = r3_m;
        n_dec.day   = day;
        n_dec.leap  = r3_leap;
        n_dec.valid = ok;
        n_dec.doy   = ok ? doy : '0;
        n_dec.dnum  = r3_base + DNUM_W'(doy) - 18'd1;
    end

    always_ff @(posedge i_clk) begin
        r_dec <= n_dec;
    end

    assign o_dec = r_dec;

endmodule

`default_nettype wire

/* rtl/calendar_date_unit.sv */
// ============================================================================
// calendar_date_unit: Gregorian date split, check, ordinal day and weekday
// o_done strobes together with the result, which passes through the input register,
// four decode stages and the result register.
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// Reset clears only the stage valid bits and r_done; payload registers are not reset.
// ============================================================================
`default_nettype none

module calendar_date_unit (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           start,
    output logic                          busy,
    input  wire [cdu_pkg::DATE_W-1:0]     i_date_a,
    input  wire [cdu_pkg::DATE_W-1:0]     i_date_b,
    output logic                          o_done,
    output logic [cdu_pkg::YEAR_W-1:0]    o_year_part,
    output logic [cdu_pkg::MD_W-1:0]      o_month_part,
    output logic [cdu_pkg::MD_W-1:0]      o_day_part,
    output logic [2:0]                    o_quarter,
    output logic                          o_leap_year,
    output logic                          o_a_valid,
    output logic [cdu_pkg::DOY_W-1:0]     o_day_of_year,
    output logic [cdu_pkg::DOY_W-1:0]     o_days_left,
    output logic [2:0]                    o_weekday,
    output logic                          o_both_valid,
    output logic [cdu_pkg::DNUM_W-1:0]    o_day_distance
);
    import cdu_pkg::*;

    logic [DATE_W-1:0]   r_date_a;
    logic [DATE_W-1:0]   r_date_b;
    logic [DEC_STAGES:0] r_vld;
    t_dec                dec_a;
    t_dec                dec_b;

    logic [2:0]          n_quarter;
    logic                both;
    logic [DNUM_W-1:0]   gap;
    logic [DOY_W-1:0]    year_len;

    logic                r_done;
    logic [YEAR_W-1:0]   r_year;
    logic [MD_W-1:0]     r_month;
    logic [MD_W-1:0]     r_day;
    logic [2:0]          r_quarter;
    logic                r_leap;
    logic                r_a_valid;
    logic [DOY_W-1:0]    r_doy;
    logic [DOY_W-1:0]    r_left;
    logic [2:0]          r_weekday;
    logic                r_both;
    logic [DNUM_W-1:0]   r_dist;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[DEC_STAGES-1:0], start};
            r_done <= r_vld[DEC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_date_a <= i_date_a;
            r_date_b <= i_date_b;
        end
    end

    cdu_decode u_dec_a (
        .i_clk  (i_clk),
        .i_date (r_date_a),
        .o_dec  (dec_a)
    );

    cdu_decode u_dec_b (
        .i_clk  (i_clk),
        .i_date (r_date_b),
        .o_dec  (dec_b)
    );

    always_comb begin
        case (dec_a.month) inside
            [7'd1:7'd3]:   n_quarter = 3'd1;
            [7'd4:7'd6]:   n_quarter = 3'd2;
            [7'd7:7'd9]:   n_quarter = 3'd3;
            [7'd10:7'd12]: n_quarter = 3'd4;
            default:       n_quarter = 3'd0;
        endcase
        both     = dec_a.valid && dec_b.valid;
        gap      = (dec_a.dnum >= dec_b.dnum) ? (dec_a.dnum - dec_b.dnum)
                                              : (dec_b.dnum - dec_a.dnum);
        year_len = dec_a.leap ? DAYS_LEAP : DAYS_COMMON;
    end

    always_ff @(posedge i_clk) begin
        r_year    <= dec_a.year;
        r_month   <= dec_a.month;
        r_day     <= dec_a.day;
        r_quarter <= n_quarter;
        r_leap    <= dec_a.leap;
        r_a_valid <= dec_a.valid;
        r_doy     <= dec_a.doy;
        r_left    <= dec_a.valid ? (year_len - dec_a.doy) : '0;
        r_weekday <= dec_a.valid ? mod7(dec_a.dnum) : 3'd0;
        r_both    <= both;
        r_dist    <= both ? gap : '0;
    end

    assign o_done         = r_done;
    assign o_year_part    = r_year;
    assign o_month_part   = r_month;
    assign o_day_part     = r_day;
    assign o_quarter      = r_quarter;
    assign o_leap_year    = r_leap;
    assign o_a_valid      = r_a_valid;
    assign o_day_of_year  = r_doy;
    assign o_days_left    = r_left;
    assign o_weekday      = r_weekday;
    assign o_both_valid   = r_both;
    assign o_day_distance = r_dist;

endmodule

`default_nettype wire
